// ----- design/pid_temperature_controller_macros.svh -----
// pid_temperature_controller_macros.svh: assertion macros for the PID temperature controller.
// Included by the checker; no other dependencies.
`ifndef PID_TEMPERATURE_CONTROLLER_MACROS_SVH
`define PID_TEMPERATURE_CONTROLLER_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define PIDTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidtc: same-cycle check failed");

// next-cycle implication, quiet while reset is asserted
`define PIDTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidtc: next-cycle check failed");

`endif

// ----- design/pidtc_pkg.sv -----
`timescale 1ns / 1ps
// pidtc_pkg.sv: widths, constants and types shared by the PID temperature controller.
// No dependencies; imported by every module of the block.
package pidtc_pkg;

    // field and datapath widths
    localparam int SAMPLE_W = 10;
    localparam int TEMP_W   = 17;
    localparam int DUTY_W   = 12;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = TEMP_W + 1;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int DERIV_W  = 23;
    localparam int ACC_W    = 32;
    localparam int QUOT_W   = 14;
    localparam int U_W      = 48;
    localparam int CFG_W    = 17;

    localparam int CAL_SAMPLES_DEFAULT = 120;

    // sample to Q.8 degrees: 84480/1023 = 82 + 594/1023, rounded
    localparam int TEMP_INT         = 82;
    localparam int TEMP_FRAC        = 594;
    localparam int TEMP_RND         = 512;   // 511 for rounding, plus one for the reciprocal
    localparam int FRAC_W           = 20;
    localparam int RECIP_1023       = 1025;  // 1025 / 2^20 is just under 1/1023
    localparam int RECIP_1023_SHIFT = 20;

    // magnitude / 10 by reciprocal, exact below 2^18
    localparam int RECIP_10       = 209716;
    localparam int RECIP_10_SHIFT = 21;

    localparam int DERIV_SCALE    = 10;
    localparam int SETPOINT_RESET = 19968;
    localparam int CAL_DUTY       = 1500;
    localparam int DUTY_MAX       = 3000;
    localparam int DUTY_SCALE     = 30;
    localparam int U_FRAC_BITS    = 16;
    localparam int U_LIMIT        = 100 * 65536;
    localparam int MID_W          = 23;      // u in the middle band fits here

    typedef enum logic [1:0] {
        CFG_SETPOINT,
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D
    } cfg_index_t;

    typedef struct packed {
        logic [TEMP_W-1:0]        setpoint;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
    } pidtc_cfg_t;

    // control-law word handed to the mixing pipeline
    typedef struct packed {
        logic [TEMP_W-1:0]         temp;
        logic                      calibrating;
        logic                      cal_end;
        logic signed [ERR_W-1:0]   err;
        logic signed [ACC_W-1:0]   acc;
        logic signed [DERIV_W-1:0] deriv;
    } pidtc_law_t;

endpackage

// ----- design/pidtc_cfg.sv -----
`timescale 1ns / 1ps
// pidtc_cfg.sv: configuration register file (setpoint and the three gains).
// Depends on pidtc_pkg.
module pidtc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    output logic                          ready,
    input  pidtc_pkg::cfg_index_t         index,
    input  logic [pidtc_pkg::CFG_W-1:0]   data,
    output pidtc_pkg::pidtc_cfg_t         cfg
);
    import pidtc_pkg::*;

    logic [TEMP_W-1:0]        setpoint_reg;
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;

    // writes are always taken
    assign ready = 1'b1;

    // register decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= TEMP_W'(SETPOINT_RESET);
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
        end
        else if (valid)
        begin
            unique case (index)
                CFG_SETPOINT: setpoint_reg <= data[TEMP_W-1:0];
                CFG_GAIN_P:   gain_p_reg   <= data[GAIN_W-1:0];
                CFG_GAIN_I:   gain_i_reg   <= data[GAIN_W-1:0];
                CFG_GAIN_D:   gain_d_reg   <= data[GAIN_W-1:0];
            endcase
        end
    end

    assign cfg.setpoint = setpoint_reg;
    assign cfg.gain_p   = gain_p_reg;
    assign cfg.gain_i   = gain_i_reg;
    assign cfg.gain_d   = gain_d_reg;

endmodule

// ----- design/pidtc_scale.sv -----
`timescale 1ns / 1ps
// pidtc_scale.sv: input register and two-stage sample-to-temperature scaling.
// Depends on pidtc_pkg.
module pidtc_scale (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pidtc_pkg::SAMPLE_W-1:0] sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pidtc_pkg::TEMP_W-1:0]   temp
);
    import pidtc_pkg::*;

    localparam int PROD_W = FRAC_W + 11;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [TEMP_W-1:0]   base_reg, base_next;
    logic [TEMP_W-1:0]   temp_reg, temp_next;
    logic [PROD_W-1:0]   recip_prod;

    // ready chain: a stage takes a word when empty or when it drains
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // T = 82*s + floor((594*s + 511) / 1023)
    assign base_next  = TEMP_W'(sample_reg) * TEMP_W'(TEMP_INT);
    assign frac_next  = FRAC_W'(sample_reg) * FRAC_W'(TEMP_FRAC) + FRAC_W'(TEMP_RND);
    assign recip_prod = PROD_W'(frac_reg) * PROD_W'(RECIP_1023);
    assign temp_next  = base_reg + TEMP_W'(recip_prod[PROD_W-1:RECIP_1023_SHIFT]);

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            sample_reg <= sample;
        end
        if (s1_valid_reg && s2_ready)
        begin
            frac_reg <= frac_next;
            base_reg <= base_next;
        end
        if (s2_valid_reg && s3_ready)
        begin
            temp_reg <= temp_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign temp      = temp_reg;

endmodule

// ----- design/pidtc_law.sv -----
`timescale 1ns / 1ps
// pidtc_law.sv: calibration count, error, derivative and saturating integral.
// Depends on pidtc_pkg. Holds all state that carries from one sample to the next.
module pidtc_law #(
    parameter int CAL_SAMPLES = pidtc_pkg::CAL_SAMPLES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pidtc_pkg::TEMP_W-1:0] setpoint,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pidtc_pkg::TEMP_W-1:0] temp,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pidtc_pkg::pidtc_law_t        word
);
    import pidtc_pkg::*;

    localparam int COUNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int QPROD_W = TEMP_W + 18;
    localparam int SUM_W   = ACC_W + 1;

    // carried state
    logic [COUNT_W-1:0]      count_reg;
    logic signed [ERR_W-1:0] prev_err_reg;
    logic signed [ACC_W-1:0] integral_reg;

    // stage A: error terms
    logic                      a_valid_reg;
    logic                      a_ready;
    logic [TEMP_W-1:0]         a_temp_reg;
    logic                      a_cal_reg;
    logic                      a_end_reg;
    logic signed [ERR_W-1:0]   a_err_reg;
    logic [QUOT_W-1:0]         a_quot_reg;
    logic                      a_neg_reg;
    logic signed [DERIV_W-1:0] a_deriv_reg;

    // stage B: finished word
    logic       b_valid_reg;
    logic       b_ready;
    pidtc_law_t b_word_reg;

    logic                      cal_now;
    logic [COUNT_W-1:0]        count_inc;
    logic                      cal_end;
    logic signed [ERR_W-1:0]   err;
    logic [TEMP_W-1:0]         err_mag;
    logic [QPROD_W-1:0]        quot_prod;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DERIV_W-1:0] deriv;
    logic signed [SUM_W-1:0]   quot_ext;
    logic signed [SUM_W-1:0]   quot_s;
    logic signed [SUM_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_sat;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // calibration phase bookkeeping
    assign cal_now   = count_reg < COUNT_W'(CAL_SAMPLES);
    assign count_inc = count_reg + 1'b1;
    assign cal_end   = count_inc == COUNT_W'(CAL_SAMPLES);

    // error, |error|/10 by reciprocal, derivative
    assign err       = ERR_W'(setpoint) - ERR_W'(temp);
    assign err_mag   = err[ERR_W-1] ? TEMP_W'(-err) : err[TEMP_W-1:0];
    assign quot_prod = QPROD_W'(err_mag) * QPROD_W'(RECIP_10);
    assign diff      = DIFF_W'(err) - DIFF_W'(prev_err_reg);
    assign deriv     = DERIV_W'(diff) * DERIV_W'(DERIV_SCALE);

    // integral: signed quotient (truncated toward zero), saturating add
    assign quot_ext = {{(SUM_W - QUOT_W){1'b0}}, a_quot_reg};
    assign quot_s   = a_neg_reg ? -quot_ext : quot_ext;
    assign acc_sum  = SUM_W'(integral_reg) + quot_s;

    always_comb
    begin
        if (acc_sum[SUM_W-1] != acc_sum[ACC_W-1])
        begin
            acc_sat = acc_sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                       : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // control state: valids, count, previous error, integral
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            count_reg    <= '0;
            prev_err_reg <= '0;
            integral_reg <= '0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (in_valid && a_ready)
            begin
                if (cal_now)
                begin
                    count_reg <= count_inc;
                end
                else
                begin
                    prev_err_reg <= err;
                end
            end
            if (a_valid_reg && b_ready && !a_cal_reg)
            begin
                integral_reg <= acc_sat;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_temp_reg  <= temp;
            a_cal_reg   <= cal_now;
            a_end_reg   <= cal_end;
            a_err_reg   <= err;
            a_quot_reg  <= quot_prod[QPROD_W-1:RECIP_10_SHIFT];
            a_neg_reg   <= err[ERR_W-1];
            a_deriv_reg <= deriv;
        end
        if (a_valid_reg && b_ready)
        begin
            b_word_reg.temp        <= a_temp_reg;
            b_word_reg.calibrating <= a_cal_reg;
            b_word_reg.cal_end     <= a_end_reg;
            b_word_reg.err         <= a_err_reg;
            b_word_reg.acc         <= acc_sat;
            b_word_reg.deriv       <= a_deriv_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign word      = b_word_reg;

endmodule

// ----- design/pidtc_mix.sv -----
`timescale 1ns / 1ps
// pidtc_mix.sv: gain products, control sum, duty clamp/scale and the output register.
// Depends on pidtc_pkg.
module pidtc_mix (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [pidtc_pkg::GAIN_W-1:0] gain_p,
    input  logic signed [pidtc_pkg::GAIN_W-1:0] gain_i,
    input  logic signed [pidtc_pkg::GAIN_W-1:0] gain_d,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pidtc_pkg::pidtc_law_t               word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pidtc_pkg::DUTY_W-1:0]        duty,
    output logic [pidtc_pkg::TEMP_W-1:0]        temperature,
    output logic                                calibrating
);
    import pidtc_pkg::*;

    localparam int PROP_W   = GAIN_W + ERR_W;
    localparam int INTG_W   = GAIN_W + ACC_W;
    localparam int DER_W    = GAIN_W + DERIV_W;
    localparam int SCALED_W = MID_W + 5;

    // stage P: products
    logic                     p_valid_reg;
    logic                     p_ready;
    logic [TEMP_W-1:0]        p_temp_reg;
    logic                     p_cal_reg;
    logic                     p_end_reg;
    logic signed [PROP_W-1:0] p_prop_reg, prop_next;
    logic signed [INTG_W-1:0] p_intg_reg, intg_next;
    logic signed [DER_W-1:0]  p_der_reg, der_next;

    // stage U: control value
    logic                  u_valid_reg;
    logic                  u_ready;
    logic [TEMP_W-1:0]     u_temp_reg;
    logic                  u_cal_reg;
    logic                  u_end_reg;
    logic signed [U_W-1:0] u_reg, u_next;

    // stage O: output register
    logic               o_valid_reg;
    logic               o_ready;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [TEMP_W-1:0]  temp_reg;
    logic               cal_reg;

    logic                over_limit;
    logic                below_zero;
    logic [SCALED_W-1:0] scaled;

    assign o_ready  = !o_valid_reg || out_ready;
    assign u_ready  = !u_valid_reg || o_ready;
    assign p_ready  = !p_valid_reg || u_ready;
    assign in_ready = p_ready;

    // Q8.8 gain times Q.8 operand gives Q.16
    assign prop_next = PROP_W'(gain_p) * PROP_W'(word.err);
    assign intg_next = INTG_W'(gain_i) * INTG_W'(word.acc);
    assign der_next  = DER_W'(gain_d) * DER_W'(word.deriv);

    assign u_next = U_W'(p_prop_reg) + U_W'(p_intg_reg) + U_W'(p_der_reg);

    // clamp bands; middle band is floor(u * 30) with u in Q.16
    assign over_limit = u_reg > U_W'(U_LIMIT);
    assign below_zero = u_reg[U_W-1];
    assign scaled     = SCALED_W'(u_reg[MID_W-1:0]) * SCALED_W'(DUTY_SCALE);

    always_comb
    begin
        if (u_cal_reg)
        begin
            duty_next = u_end_reg ? DUTY_W'(CAL_DUTY) : '0;
        end
        else if (over_limit)
        begin
            duty_next = DUTY_W'(DUTY_MAX);
        end
        else if (below_zero)
        begin
            duty_next = '0;
        end
        else
        begin
            duty_next = scaled[SCALED_W-1:U_FRAC_BITS];
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            u_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= in_valid;
            end
            if (u_ready)
            begin
                u_valid_reg <= p_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= u_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && p_ready)
        begin
            p_temp_reg <= word.temp;
            p_cal_reg  <= word.calibrating;
            p_end_reg  <= word.cal_end;
            p_prop_reg <= prop_next;
            p_intg_reg <= intg_next;
            p_der_reg  <= der_next;
        end
        if (p_valid_reg && u_ready)
        begin
            u_temp_reg <= p_temp_reg;
            u_cal_reg  <= p_cal_reg;
            u_end_reg  <= p_end_reg;
            u_reg      <= u_next;
        end
        if (u_valid_reg && o_ready)
        begin
            duty_reg <= duty_next;
            temp_reg <= u_temp_reg;
            cal_reg  <= u_cal_reg;
        end
    end

    assign out_valid   = o_valid_reg;
    assign duty        = duty_reg;
    assign temperature = temp_reg;
    assign calibrating = cal_reg;

endmodule

// ----- design/pid_temperature_controller.sv -----
`timescale 1ns / 1ps
// pid_temperature_controller.sv: top level of the PID temperature controller.
// Depends on pidtc_pkg, pidtc_cfg, pidtc_scale, pidtc_law and pidtc_mix.

// Takes one 10-bit sensor sample per word and returns one word with the scaled
// temperature (Q.8 degrees), the PWM duty and a calibration flag. The first
// CAL_SAMPLES words only count (duty 0, and 1500 on the last of them); after
// that each word runs one PID step with saturating integral and clamped duty.
// The datapath is an eight-register pipeline (scale s1-s3, law A and B, mix P,
// U and O): a new sample can be accepted every cycle while in_stall is low. The
// counter, previous error and integral are each read and updated within a single
// stage, so consecutive samples follow back to back. in_stall rises only when the
// output word is stalled and the pipeline is full. The user must write registers
// only while no samples are in flight (not enforced); writes are never held off.
module pid_temperature_controller #(
    parameter int CAL_SAMPLES = pidtc_pkg::CAL_SAMPLES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pidtc_pkg::SAMPLE_W-1:0] adc_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pidtc_pkg::DUTY_W-1:0]   duty,
    output logic [pidtc_pkg::TEMP_W-1:0]   temperature,
    output logic                           calibrating,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  pidtc_pkg::cfg_index_t          cfg_index,
    input  logic [pidtc_pkg::CFG_W-1:0]    cfg_data
);
    import pidtc_pkg::*;

    pidtc_cfg_t        cfg;
    logic              scale_in_ready;
    logic              scale_valid;
    logic              law_in_ready;
    logic [TEMP_W-1:0] scale_temp;
    logic              law_valid;
    logic              mix_in_ready;
    pidtc_law_t        law_word;

    assign in_stall = !scale_in_ready;

    // configuration registers
    pidtc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (cfg_valid),
        .ready (cfg_ready),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    // sample scaling
    pidtc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (scale_in_ready),
        .sample    (adc_sample),
        .out_valid (scale_valid),
        .out_ready (law_in_ready),
        .temp      (scale_temp)
    );

    // calibration and error terms
    pidtc_law #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_law (
        .clk       (clk),
        .rst_n     (rst_n),
        .setpoint  (cfg.setpoint),
        .in_valid  (scale_valid),
        .in_ready  (law_in_ready),
        .temp      (scale_temp),
        .out_valid (law_valid),
        .out_ready (mix_in_ready),
        .word      (law_word)
    );

    // gains, sum and duty
    pidtc_mix u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .gain_p      (cfg.gain_p),
        .gain_i      (cfg.gain_i),
        .gain_d      (cfg.gain_d),
        .in_valid    (law_valid),
        .in_ready    (mix_in_ready),
        .word        (law_word),
        .out_valid   (out_valid),
        .out_ready   (!out_stall),
        .duty        (duty),
        .temperature (temperature),
        .calibrating (calibrating)
    );

endmodule

// ----- design/pidtc_checker.sv -----
`timescale 1ns / 1ps
// pidtc_checker.sv: port-level checks for the PID temperature controller, bound to the top.
// Depends on pidtc_pkg and pid_temperature_controller_macros.svh.
`include "pid_temperature_controller_macros.svh"

module pidtc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [pidtc_pkg::DUTY_W-1:0] duty,
    input logic [pidtc_pkg::TEMP_W-1:0] temperature,
    input logic                         calibrating
);
    import pidtc_pkg::*;

    // a stalled output word holds
    `PIDTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(duty) && $stable(temperature) && $stable(calibrating))

    // input is only held off when the output word is stuck; a_in_free is always true
    `PIDTC_ASSERT_IMPLY(a_in_free, clk, rst_n, !out_valid || !out_stall, !in_stall || !in_valid || in_valid)
    `PIDTC_ASSERT_IMPLY(a_no_stall, clk, rst_n, !out_valid || !out_stall, !in_stall)

    // once control is active, calibration never comes back
    `PIDTC_ASSERT_NEXT(a_cal_over, clk, rst_n, out_valid && !calibrating, !calibrating)

    // calibration words carry only the idle or the hand-over duty
    `PIDTC_ASSERT_IMPLY(a_cal_duty, clk, rst_n, out_valid && calibrating, duty == '0 || duty == DUTY_W'(CAL_DUTY))

endmodule

bind pid_temperature_controller pidtc_checker u_pidtc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .duty        (duty),
    .temperature (temperature),
    .calibrating (calibrating)
);
